/* sv/pfc_pkg.sv */
package pfc_pkg;

  // Pixel format codes, shared by the configuration register and the input word.
  typedef enum logic [2:0] {
    FMT_R8      = 3'd0,
    FMT_RG8     = 3'd1,
    FMT_RGB8    = 3'd2,
    FMT_RGBA8   = 3'd3,
    FMT_R32F    = 3'd4,
    FMT_RG32F   = 3'd5,
    FMT_RGB32F  = 3'd6,
    FMT_RGBA32F = 3'd7
  } pfc_fmt_e;

  localparam int unsigned NumLanes = 4;

  // Single-precision constants.
  localparam logic [31:0] FloatOne  = 32'h3F80_0000;
  localparam logic [31:0] FloatZero = 32'h0000_0000;
  localparam logic [7:0]  ExpInfNan = 8'hFF;
  localparam logic [7:0]  ExpOne    = 8'd127;
  // Below 2^-8 the scaled value stays under one.
  localparam logic [7:0]  ExpMinByte = 8'd119;
  // Exponent bias plus fraction width, used to align the scaled product.
  localparam logic [7:0]  ExpAlign  = 8'd150;

  typedef struct packed {
    logic [2:0]  src_fmt;
    logic [31:0] in_word0;
    logic [31:0] in_word1;
    logic [31:0] in_word2;
    logic [31:0] in_word3;
  } pfc_in_t;

  typedef struct packed {
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [31:0] out_word3;
    logic        status;
  } pfc_out_t;

  // What each lane hands to the merge stage.
  typedef struct packed {
    logic [7:0]  byte_val;
    logic [31:0] chan_val;
  } pfc_lane_t;

endpackage

/* sv/pfc_lane.sv */
module pfc_lane (
  input  logic [31:0]       chan_i,
  input  logic [7:0]        byte_i,
  output pfc_pkg::pfc_lane_t lane_o
);
  import pfc_pkg::*;

  logic        sgn;
  logic [7:0]  expo;
  logic [22:0] frac;
  logic [23:0] mant;
  logic [31:0] prod;
  logic [23:0] keep;
  logic        guard;
  logic        sticky;
  logic        rnd_up;
  logic [32:0] rounded;
  logic [7:0]  shamt;
  logic [32:0] scaled;
  logic [7:0]  byte_val;

  logic [2:0]  lead;
  logic [39:0] rep;
  logic [39:0] norm;
  logic [7:0]  w_exp;
  logic [31:0] w_bits;

  // Float channel to byte: clamp to [0,1], round the product with 255 to a single, truncate.
  always_comb begin
    sgn   = chan_i[31];
    expo  = chan_i[30:23];
    frac  = chan_i[22:0];
    mant  = {1'b1, frac};
    prod  = {mant, 8'd0} - {8'd0, mant};
    if (prod[31]) begin
      keep   = prod[31:8];
      guard  = prod[7];
      sticky = |prod[6:0];
    end else begin
      keep   = prod[30:7];
      guard  = prod[6];
      sticky = |prod[5:0];
    end
    rnd_up  = guard & (sticky | keep[0]);
    rounded = {9'd0, keep} + {32'd0, rnd_up};
    if (prod[31]) begin
      rounded = rounded << 8;
    end else begin
      rounded = rounded << 7;
    end
    shamt  = ExpAlign - expo;
    scaled = rounded >> shamt[4:0];

    if (expo == ExpInfNan && frac != 23'd0) begin
      byte_val = 8'd0;
    end else if (sgn) begin
      byte_val = 8'd0;
    end else if (expo >= ExpOne) begin
      byte_val = 8'hFF;
    end else if (expo < ExpMinByte) begin
      byte_val = 8'd0;
    end else begin
      byte_val = scaled[7:0];
    end
  end

  // Byte to float: byte/255 is the byte repeated forever after the binary point.
  always_comb begin
    lead = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (byte_i[i]) begin
        lead = 3'(i);
      end
    end
    rep   = {byte_i, byte_i, byte_i, byte_i, byte_i};
    norm  = rep << (3'd7 - lead);
    w_exp = 8'd119 + {5'd0, lead};
    // The tail never ends in a tie, so a set guard bit always rounds up.
    w_bits = {1'b0, w_exp, norm[38:16]} + {31'd0, norm[15]};
    if (byte_i == 8'd0) begin
      w_bits = FloatZero;
    end else if (byte_i == 8'hFF) begin
      w_bits = FloatOne;
    end
  end

  assign lane_o.byte_val = byte_val;
  assign lane_o.chan_val = w_bits;

endmodule

/* sv/pfc_merge.sv */
module pfc_merge (
  input  pfc_pkg::pfc_in_t                       in_i,
  input  logic [2:0]                             dst_i,
  input  pfc_pkg::pfc_lane_t [pfc_pkg::NumLanes-1:0] lanes_i,
  output pfc_pkg::pfc_out_t                      out_o
);
  import pfc_pkg::*;

  logic [31:0] w0;
  logic [31:0] w1;
  logic [31:0] w2;
  logic [31:0] w3;
  logic        st;

  // Pick copy, narrowing, widening or no path from the format pair.
  always_comb begin
    w0 = '0;
    w1 = '0;
    w2 = '0;
    w3 = '0;
    st = 1'b0;
    if (in_i.src_fmt == dst_i) begin
      case (in_i.src_fmt)
        FMT_R8:      w0 = {24'd0, in_i.in_word0[7:0]};
        FMT_RG8:     w0 = {16'd0, in_i.in_word0[15:0]};
        FMT_RGB8:    w0 = {8'd0, in_i.in_word0[23:0]};
        FMT_RGBA8:   w0 = in_i.in_word0;
        FMT_R32F:    w0 = in_i.in_word0;
        FMT_RG32F: begin
          w0 = in_i.in_word0;
          w1 = in_i.in_word1;
        end
        FMT_RGB32F: begin
          w0 = in_i.in_word0;
          w1 = in_i.in_word1;
          w2 = in_i.in_word2;
        end
        FMT_RGBA32F: begin
          w0 = in_i.in_word0;
          w1 = in_i.in_word1;
          w2 = in_i.in_word2;
          w3 = in_i.in_word3;
        end
        default: w0 = '0;
      endcase
    end else if (in_i.src_fmt == FMT_RGBA32F && dst_i == FMT_RGBA8) begin
      w0 = {lanes_i[3].byte_val, lanes_i[2].byte_val,
            lanes_i[1].byte_val, lanes_i[0].byte_val};
    end else if (in_i.src_fmt == FMT_RGBA8 && dst_i == FMT_RGBA32F) begin
      w0 = lanes_i[0].chan_val;
      w1 = lanes_i[1].chan_val;
      w2 = lanes_i[2].chan_val;
      w3 = lanes_i[3].chan_val;
    end else begin
      st = 1'b1;
    end
  end

  assign out_o.out_word0 = w0;
  assign out_o.out_word1 = w1;
  assign out_o.out_word2 = w2;
  assign out_o.out_word3 = w3;
  assign out_o.status    = st;

endmodule

/* sv/pixel_format_converter.sv */
// Pixel format converter.
// Input channel: in_valid_i / in_stall_o carry one pixel word (source format and
// four 32-bit words). Output channel: out_valid_o / out_stall_i carry the converted
// word and a status bit that is set when no conversion path exists.
// The user must write the destination format through cfg_we_i / cfg_wdata_i only
// while idle; the block does not enforce this. An accepted word is registered and
// shown in the next cycle. Throughput is one word per cycle while the receiver
// does not stall; four float lanes work on the channels side by side and a merge
// stage forms the result in the same cycle, ahead of the single output register.
// The input is stalled only while a result is held and the receiver stalls;
// a word is taken in the same cycle that the held result leaves.
// Reset empties the output register and sets the destination format to RGBA8.
module pixel_format_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pfc_pkg::pfc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pfc_pkg::pfc_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_wdata_i
);
  import pfc_pkg::*;

  logic [2:0]            atlas_q;
  logic                  valid_q;
  pfc_out_t              data_q;
  pfc_out_t              data_d;
  pfc_lane_t [NumLanes-1:0] lanes;
  logic [NumLanes-1:0][31:0] words;
  logic                  accept;

  assign words = {in_data_i.in_word3, in_data_i.in_word2,
                  in_data_i.in_word1, in_data_i.in_word0};

  // One lane per channel.
  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    pfc_lane u_lane (
      .chan_i (words[k]),
      .byte_i (in_data_i.in_word0[8*k +: 8]),
      .lane_o (lanes[k])
    );
  end

  pfc_merge u_merge (
    .in_i    (in_data_i),
    .dst_i   (atlas_q),
    .lanes_i (lanes),
    .out_o   (data_d)
  );

  assign in_stall_o = valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_q <= FMT_RGBA8;
    end else if (cfg_we_i) begin
      atlas_q <= cfg_wdata_i;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* sv/pfc_checker.sv */
module pfc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pfc_pkg::pfc_out_t out_data_o
);
  import pfc_pkg::*;

  // A new word appears only after one was accepted.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("output word without an accepted input");

  // The input stalls only behind a held, stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without cause");

  // A word with no path carries all-zero data.
  a_nopath_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |->
      (out_data_o.out_word0 == '0 && out_data_o.out_word1 == '0 &&
       out_data_o.out_word2 == '0 && out_data_o.out_word3 == '0))
    else $error("no-path word carries data");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output changed");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
